// ===== src/tpps_pkg.sv =====
// Shared constants and types for the triangle pair plane separation test.
package tpps_pkg;

  // Width of one packed vertex port.
  localparam int VTX_BITS = 48;

  // Pipeline stages inside each lane.
  localparam int NUM_STAGES = 5;

  // Per-stage load enables handed from the top level to both lanes.
  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
  } lane_ctl_t;

  // Sign flags of the three vertex distances found by one lane.
  typedef struct packed {
    logic [2:0] pos;
    logic [2:0] neg;
  } dist_flags_t;

endpackage

// ===== src/tpps_lane.sv =====
// One lane: plane normal of the own triangle and distance signs of the other one.
module tpps_lane #(
  parameter int COORD_BITS = 16
) (
  input  logic                                       clk,
  input  tpps_pkg::lane_ctl_t                        ctl,
  input  logic [2:0][tpps_pkg::VTX_BITS-1:0]         own_vtx,
  input  logic [2:0][tpps_pkg::VTX_BITS-1:0]         oth_vtx,
  output tpps_pkg::dist_flags_t                      flags
);

  localparam int DW   = COORD_BITS + 1;          // edge / offset vector
  localparam int PW   = 2 * COORD_BITS + 2;      // cross-product partials
  localparam int NW   = 2 * COORD_BITS + 3;      // normal components
  localparam int QW   = 3 * COORD_BITS + 4;      // dot-product partials
  localparam int SW   = 3 * COORD_BITS + 6;      // full distance
  localparam int PADW = (3 * COORD_BITS > tpps_pkg::VTX_BITS) ?
                        3 * COORD_BITS : tpps_pkg::VTX_BITS;

  logic [2:0][PADW-1:0]                    own_w;
  logic [2:0][PADW-1:0]                    oth_w;
  logic signed [COORD_BITS-1:0]            own_c [3][3];
  logic signed [COORD_BITS-1:0]            oth_c [3][3];

  logic signed [DW-1:0] e1_r [3];
  logic signed [DW-1:0] e2_r [3];
  logic signed [DW-1:0] d1_r [3][3];
  logic signed [PW-1:0] pp_r [3];
  logic signed [PW-1:0] pm_r [3];
  logic signed [DW-1:0] d2_r [3][3];
  logic signed [NW-1:0] n_r  [3];
  logic signed [DW-1:0] d3_r [3][3];
  logic signed [QW-1:0] q_r  [3][3];
  logic signed [SW-1:0] dsum [3];
  logic [2:0]           pos_r;
  logic [2:0]           neg_r;

  // Unpack coordinates; bits above the port width read as zero.
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      own_w[v] = PADW'(own_vtx[v]);
      oth_w[v] = PADW'(oth_vtx[v]);
      for (int i = 0; i < 3; i++) begin
        own_c[v][i] = own_w[v][i*COORD_BITS +: COORD_BITS];
        oth_c[v][i] = oth_w[v][i*COORD_BITS +: COORD_BITS];
      end
    end
  end

  // Stage 1: edge vectors and offsets of the other vertices from own vertex 0.
  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= DW'(own_c[1][i]) - DW'(own_c[0][i]);
        e2_r[i] <= DW'(own_c[2][i]) - DW'(own_c[0][i]);
        for (int k = 0; k < 3; k++) begin
          d1_r[k][i] <= DW'(oth_c[k][i]) - DW'(own_c[0][i]);
        end
      end
    end
  end

  // Stage 2: the six cross-product partials.
  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      pp_r[0] <= PW'(e1_r[1]) * PW'(e2_r[2]);
      pm_r[0] <= PW'(e1_r[2]) * PW'(e2_r[1]);
      pp_r[1] <= PW'(e1_r[2]) * PW'(e2_r[0]);
      pm_r[1] <= PW'(e1_r[0]) * PW'(e2_r[2]);
      pp_r[2] <= PW'(e1_r[0]) * PW'(e2_r[1]);
      pm_r[2] <= PW'(e1_r[1]) * PW'(e2_r[0]);
      d2_r    <= d1_r;
    end
  end

  // Stage 3: normal components.
  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= NW'(pp_r[i]) - NW'(pm_r[i]);
      end
      d3_r <= d2_r;
    end
  end

  // Stage 4: dot-product partials for each of the other vertices.
  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          q_r[k][i] <= QW'(n_r[i]) * QW'(d3_r[k][i]);
        end
      end
    end
  end

  // Stage 5: sum the partials and keep only the sign of each distance.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsum[k] = SW'(q_r[k][0]) + SW'(q_r[k][1]) + SW'(q_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= dsum[k][SW-1];
        pos_r[k] <= !dsum[k][SW-1] && (dsum[k] != '0);
      end
    end
  end

  assign flags.pos = pos_r;
  assign flags.neg = neg_r;

endmodule

// ===== src/tpps_merge.sv =====
// Merge stage: combine both lanes' distance signs into the registered result.
module tpps_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  lane_valid,
  input  tpps_pkg::dist_flags_t flags_a,
  input  tpps_pkg::dist_flags_t flags_b,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_maybe_intersect,
  output logic                  out_split_by_a_plane,
  output logic                  out_split_by_b_plane
);

  logic valid_r;
  logic valid_nxt;
  logic sep_a_r;
  logic sep_b_r;
  logic sep_a;
  logic sep_b;

  // A plane separates when all three distances share one strict sign.
  assign sep_a = (&flags_a.pos) || (&flags_a.neg);
  assign sep_b = (&flags_b.pos) || (&flags_b.neg);

  // Load when empty or when the held item is taken.
  assign ready     = !valid_r || !out_stall;
  assign valid_nxt = ready ? lane_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the result while stalled.
  always_ff @(posedge clk) begin
    if (ready) begin
      sep_a_r <= sep_a;
      sep_b_r <= sep_b;
    end
  end

  assign out_valid            = valid_r;
  assign out_split_by_a_plane = sep_a_r;
  assign out_split_by_b_plane = sep_b_r;
  assign out_maybe_intersect  = !sep_a_r && !sep_b_r;

endmodule

// ===== src/triangle_pair_plane_separation_test.sv =====
// Top level of the triangle pair plane separation test.
//
// Input channel: in_valid / in_stall with six packed vertices, each {z,y,x}
// of COORD_BITS-wide two's complement coordinates. Output channel:
// out_valid / out_stall with maybe_intersect, split_by_a_plane and
// split_by_b_plane. An item moves at a clock edge where valid is high and
// stall is low.
// Two identical lanes run side by side: one tests B's vertices against A's
// plane, the other A's vertices against B's plane. Each lane has five
// stages (offsets, cross partials, normal, dot partials, sign); a merge
// stage holds the output register.
// An accepted item passes through the five lane stages and then the merge register.
// Throughput: one item per cycle while the receiver does not stall; the
// multipliers of stages 2 and 4 are fully pipelined.
// Reset (rst_n low, synchronous) empties every stage; payload registers are
// not cleared. When the receiver stalls, the output item holds and the
// stages fill behind it, so in_stall rises only when all six stages hold
// items.
module triangle_pair_plane_separation_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tpps_pkg::VTX_BITS-1:0] in_a_vertex0,
  input  logic [tpps_pkg::VTX_BITS-1:0] in_a_vertex1,
  input  logic [tpps_pkg::VTX_BITS-1:0] in_a_vertex2,
  input  logic [tpps_pkg::VTX_BITS-1:0] in_b_vertex0,
  input  logic [tpps_pkg::VTX_BITS-1:0] in_b_vertex1,
  input  logic [tpps_pkg::VTX_BITS-1:0] in_b_vertex2,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_maybe_intersect,
  output logic                          out_split_by_a_plane,
  output logic                          out_split_by_b_plane
);

  localparam int NS = tpps_pkg::NUM_STAGES;

  logic [NS-1:0]                          vld_r;
  logic [NS-1:0]                          vld_nxt;
  logic [NS-1:0]                          rdy;
  logic                                   mrg_rdy;
  tpps_pkg::lane_ctl_t                    ctl;
  tpps_pkg::dist_flags_t                  flags_a;
  tpps_pkg::dist_flags_t                  flags_b;
  logic [2:0][tpps_pkg::VTX_BITS-1:0]     tri_a;
  logic [2:0][tpps_pkg::VTX_BITS-1:0]     tri_b;

  assign tri_a = {in_a_vertex2, in_a_vertex1, in_a_vertex0};
  assign tri_b = {in_b_vertex2, in_b_vertex1, in_b_vertex0};

  // Stage ready chain: a stage loads when empty or when it moves on.
  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || mrg_rdy;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign ctl.ld   = rdy;
  assign in_stall = !rdy[0];

  // Advance stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Plane of A against the vertices of B.
  tpps_lane #(
    .COORD_BITS (COORD_BITS)
  ) u_lane_a (
    .clk     (clk),
    .ctl     (ctl),
    .own_vtx (tri_a),
    .oth_vtx (tri_b),
    .flags   (flags_a)
  );

  // Plane of B against the vertices of A.
  tpps_lane #(
    .COORD_BITS (COORD_BITS)
  ) u_lane_b (
    .clk     (clk),
    .ctl     (ctl),
    .own_vtx (tri_b),
    .oth_vtx (tri_a),
    .flags   (flags_b)
  );

  // Combine lanes into the output register.
  tpps_merge u_merge (
    .clk                  (clk),
    .rst_n                (rst_n),
    .lane_valid           (vld_r[NS-1]),
    .flags_a              (flags_a),
    .flags_b              (flags_b),
    .ready                (mrg_rdy),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_maybe_intersect  (out_maybe_intersect),
    .out_split_by_a_plane (out_split_by_a_plane),
    .out_split_by_b_plane (out_split_by_b_plane)
  );

endmodule
